>>> rtl/ehdr_pkg.sv
`default_nettype none
package ehdr_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  // Number of rotation steps actually run, limited to what the arctan table covers.
  localparam int CordicSteps = (CORDIC_ITERATIONS < 1) ? 1 :
                               (CORDIC_ITERATIONS > 24) ? 24 : CORDIC_ITERATIONS;
  localparam int StepW = 5;
  localparam int CordW = 34;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 24;
  localparam logic [CordW-1:0] CordicGain = 34'd652032874;

  localparam logic [CfgIdxW-1:0] RegDistPerCount = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMinInterval = 2'd1;

  typedef struct packed {
    logic signed [31:0] encoder_count;
    logic signed [15:0] heading_angle;
    logic [31:0]        time_us;
  } in_item_t;

  typedef struct packed {
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic               accepted;
  } out_item_t;

  typedef struct packed {
    logic             load;
    logic             scale;
    logic             rot;
    logic             trig;
    logic             mul_lo;
    logic             mul_hi;
    logic             acc;
    logic             rnd;
    logic             apply;
    logic             emit;
    logic             axis;
    logic [StepW-1:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic ok;
  } dp_stat_t;

  // Arctan of 2^-i, in units where 2^32 is a full turn.
  function automatic logic [CordW-1:0] atan_turns(input logic [StepW-1:0] i);
    logic [CordW-1:0] r;
    begin
      unique case (i)
        5'd0: r = 34'd536870912;
        5'd1: r = 34'd316933406;
        5'd2: r = 34'd167458907;
        5'd3: r = 34'd85004756;
        5'd4: r = 34'd42667331;
        5'd5: r = 34'd21354465;
        5'd6: r = 34'd10679838;
        5'd7: r = 34'd5340245;
        5'd8: r = 34'd2670163;
        5'd9: r = 34'd1335087;
        5'd10: r = 34'd667544;
        5'd11: r = 34'd333772;
        5'd12: r = 34'd166886;
        5'd13: r = 34'd83443;
        5'd14: r = 34'd41722;
        5'd15: r = 34'd20861;
        5'd16: r = 34'd10430;
        5'd17: r = 34'd5215;
        5'd18: r = 34'd2608;
        5'd19: r = 34'd1304;
        5'd20: r = 34'd652;
        5'd21: r = 34'd326;
        5'd22: r = 34'd163;
        5'd23: r = 34'd81;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

>>> rtl/encoder_heading_dead_reckoning_unit.sv
// Sequence, set by the controller: a tick is loaded and scaled; a rejected
// tick then goes straight to the output, an integrated one first runs 16 CORDIC
// rotations, then per axis a chunked multiply (low, high, accumulate), rounding
// and a saturating add. One transaction at a time: a new tick is taken only
// once the result is emitted, which waits while a held result is stalled.
// Reset: asynchronous active low; clears position, last count and time, loads defaults.
`default_nettype none
module encoder_heading_dead_reckoning_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire ehdr_pkg::in_item_t            in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output ehdr_pkg::out_item_t                out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [ehdr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [ehdr_pkg::CfgDataW-1:0] cfg_data_i
);

  // Controller sequences each transaction; datapath holds state and arithmetic.
  ehdr_pkg::dp_cmd_t  cmd;
  ehdr_pkg::dp_stat_t stat;

  ehdr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Output register inside the datapath holds the result while the sink stalls.
  ehdr_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire

>>> rtl/ehdr_datapath.sv
`default_nettype none
module ehdr_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire ehdr_pkg::in_item_t           in_data_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [ehdr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ehdr_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire ehdr_pkg::dp_cmd_t            cmd_i,
  output ehdr_pkg::dp_stat_t                stat_o,
  output ehdr_pkg::out_item_t               out_data_o
);

  localparam int CW = ehdr_pkg::CordW;

  logic [23:0] dpc_q;
  logic [19:0] min_int_q;
  logic [31:0] last_count_q, last_time_q;
  logic signed [47:0] x_acc_q, y_acc_q;

  logic ok_q, flip_q;
  logic signed [31:0] delta_q;
  logic signed [56:0] dist_q;
  logic signed [CW-1:0] cx_q, cy_q, cz_q;
  logic [55:0] dmag_q;
  logic [31:0] tx_q, ty_q;
  logic negx_q, negy_q;
  logic [59:0] prod_q;
  logic [87:0] acc_q;
  logic signed [57:0] inc_q;
  ehdr_pkg::out_item_t out_q;

  logic [31:0] elapsed, delta_w, ang;
  logic ok_w, flip_w;
  logic signed [56:0] dist_w;
  logic signed [CW-1:0] sx, sy, at, xa, ya;
  logic [55:0] dabs;
  logic [31:0] t_sel;
  logic [27:0] d_part;
  logic [59:0] p_w;
  logic [87:0] rsum;
  logic [57:0] mag;
  logic signed [57:0] sum, acc_sel;
  logic signed [47:0] sat;

  assign elapsed = in_data_i.time_us - last_time_q;
  assign ok_w = elapsed >= {12'b0, min_int_q};
  assign delta_w = in_data_i.encoder_count - last_count_q;
  assign ang = {in_data_i.heading_angle, 16'b0};
  // Fold the left half plane onto the right one; flip the results back later.
  assign flip_w = ang[31] ^ ang[30];

  assign dist_w = delta_q * $signed({1'b0, dpc_q});

  assign sx = cx_q >>> cmd_i.step;
  assign sy = cy_q >>> cmd_i.step;
  assign at = $signed(ehdr_pkg::atan_turns(cmd_i.step));

  assign dabs = dist_q[56] ? 56'(-dist_q) : dist_q[55:0];
  assign xa = cx_q[CW-1] ? -cx_q : cx_q;
  assign ya = cy_q[CW-1] ? -cy_q : cy_q;

  assign t_sel = cmd_i.axis ? ty_q : tx_q;
  assign d_part = cmd_i.mul_lo ? dmag_q[27:0] : dmag_q[55:28];
  assign p_w = {32'b0, d_part} * {28'b0, t_sel};

  assign rsum = acc_q + 88'(1 << 29);
  assign mag = rsum[87:30];

  assign acc_sel = cmd_i.axis ? 58'(y_acc_q) : 58'(x_acc_q);
  assign sum = acc_sel + inc_q;
  always_comb begin
    if (sum > 58'sh7FFFFFFFFFFF) begin
      sat = 48'sh7FFFFFFFFFFF;
    end else if (sum < -58'sh800000000000) begin
      sat = -48'sh800000000000;
    end else begin
      sat = sum[47:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dpc_q        <= 24'd35701;
      min_int_q    <= 20'd100;
      last_count_q <= '0;
      last_time_q  <= '0;
      x_acc_q      <= '0;
      y_acc_q      <= '0;
      ok_q         <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          ehdr_pkg::RegDistPerCount: dpc_q <= cfg_data_i;
          ehdr_pkg::RegMinInterval: min_int_q <= cfg_data_i[19:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        ok_q <= ok_w;
        if (ok_w) begin
          last_count_q <= in_data_i.encoder_count;
          last_time_q  <= in_data_i.time_us;
        end
      end
      if (cmd_i.apply) begin
        if (cmd_i.axis) begin
          y_acc_q <= sat;
        end else begin
          x_acc_q <= sat;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      delta_q <= delta_w;
      flip_q  <= flip_w;
      cx_q    <= ehdr_pkg::CordicGain;
      cy_q    <= '0;
      cz_q    <= CW'($signed({ang[31] ^ flip_w, ang[30:0]}));
    end
    if (cmd_i.scale) begin
      dist_q <= dist_w;
    end
    if (cmd_i.rot) begin
      if (!cz_q[CW-1]) begin
        cx_q <= cx_q - sy;
        cy_q <= cy_q + sx;
        cz_q <= cz_q - at;
      end else begin
        cx_q <= cx_q + sy;
        cy_q <= cy_q - sx;
        cz_q <= cz_q + at;
      end
    end
    if (cmd_i.trig) begin
      dmag_q <= dabs;
      tx_q   <= xa[31:0];
      ty_q   <= ya[31:0];
      negx_q <= dist_q[56] ^ cx_q[CW-1] ^ flip_q;
      negy_q <= dist_q[56] ^ cy_q[CW-1] ^ flip_q;
    end
    if (cmd_i.mul_lo) begin
      prod_q <= p_w;
    end
    if (cmd_i.mul_hi) begin
      acc_q  <= {28'b0, prod_q};
      prod_q <= p_w;
    end
    if (cmd_i.acc) begin
      acc_q <= acc_q + {prod_q, 28'b0};
    end
    if (cmd_i.rnd) begin
      inc_q <= (cmd_i.axis ? negy_q : negx_q) ? -$signed(mag) : $signed(mag);
    end
    if (cmd_i.emit) begin
      out_q.pos_x    <= x_acc_q;
      out_q.pos_y    <= y_acc_q;
      out_q.accepted <= ok_q;
    end
  end

  assign stat_o.ok = ok_q;
  assign out_data_o = out_q;

endmodule
`default_nettype wire

>>> rtl/ehdr_ctrl.sv
`default_nettype none
module ehdr_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  input  wire ehdr_pkg::dp_stat_t stat_i,
  output ehdr_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIST, S_ROT, S_TRIG, S_MLO, S_MHI, S_ACC, S_RND, S_APPLY, S_OUT
  } state_e;

  state_e state_q;
  logic axis_q, out_valid_q;
  logic [ehdr_pkg::StepW-1:0] step_q;
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.axis = axis_q;
    cmd_o.step = step_q;
    unique case (state_q)
      S_IDLE:  cmd_o.load = in_valid_i;
      S_DIST:  cmd_o.scale = 1'b1;
      S_ROT:   cmd_o.rot = 1'b1;
      S_TRIG:  cmd_o.trig = 1'b1;
      S_MLO:   cmd_o.mul_lo = 1'b1;
      S_MHI:   cmd_o.mul_hi = 1'b1;
      S_ACC:   cmd_o.acc = 1'b1;
      S_RND:   cmd_o.rnd = 1'b1;
      S_APPLY: cmd_o.apply = 1'b1;
      S_OUT:   cmd_o.emit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Raise valid on emit, drop it once the sink takes the result.
      if (state_q == S_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_DIST;
          end
        end
        S_DIST: begin
          step_q  <= '0;
          axis_q  <= 1'b0;
          state_q <= stat_i.ok ? S_ROT : S_OUT;
        end
        S_ROT: begin
          if (step_q == ehdr_pkg::StepW'(ehdr_pkg::CordicSteps - 1)) begin
            state_q <= S_TRIG;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        S_TRIG:  state_q <= S_MLO;
        S_MLO:   state_q <= S_MHI;
        S_MHI:   state_q <= S_ACC;
        S_ACC:   state_q <= S_RND;
        S_RND:   state_q <= S_APPLY;
        S_APPLY: begin
          // Advance to the y axis, or finish after it.
          if (axis_q) begin
            state_q <= S_OUT;
          end else begin
            axis_q  <= 1'b1;
            state_q <= S_MLO;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> sim/ehdr_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module ehdr_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_stall_i,
  input  wire ehdr_pkg::in_item_t            in_data_i,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_stall_i,
  input  wire ehdr_pkg::out_item_t           out_data_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [ehdr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [ehdr_pkg::CfgDataW-1:0] cfg_data_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);

  localparam longint PosMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint PosMin = -PosMax - 1;

  localparam longint AtanTurns [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81};

  logic [23:0] dist_per_count;
  logic [19:0] min_gap_us;
  logic [31:0] prev_count;
  logic [31:0] prev_stamp;
  longint      x_pos;
  longint      y_pos;
  ehdr_pkg::out_item_t expected_pos_q[$];

  // Heading to cos and sin in Q30.
  function automatic void heading_trig(input logic [15:0] h, output longint c,
                                       output longint s);
    logic [31:0] a;
    logic        flip;
    longint      x, y, z, dx, dy;
    a = {h, 16'h0000};
    flip = 1'b0;
    if (a >= 32'h4000_0000 && a < 32'hC000_0000) begin
      a = a - 32'h8000_0000;
      flip = 1'b1;
    end
    z = longint'($signed(a));
    x = 652032874;
    y = 0;
    for (int i = 0; i < ehdr_pkg::CordicSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - AtanTurns[i];
      end else begin
        x = x + dx; y = y - dy; z = z + AtanTurns[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // distance * trig / 2^30, rounded half away from zero
  function automatic longint scaled_step(input longint travel, input longint trig);
    logic        neg;
    logic [63:0] d, t, mag;
    neg = (travel < 0) != (trig < 0);
    d = travel < 0 ? -travel : travel;
    t = trig < 0 ? -trig : trig;
    mag = (d >> 30) * t + (((d & 64'h3FFF_FFFF) * t + 64'h2000_0000) >> 30);
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint clamp_add(input longint acc, input longint inc);
    longint sum;
    sum = acc + inc;
    if (sum > PosMax) return PosMax;
    if (sum < PosMin) return PosMin;
    return sum;
  endfunction

  task automatic report(input string what, input logic [47:0] got,
                        input logic [47:0] want);
    $display("tb: mismatch %s got %h want %h at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ehdr_pkg::out_item_t res;
    ehdr_pkg::out_item_t want;
    logic [31:0] elapsed;
    logic [31:0] du;
    longint      travel, c, s;
    if (!rst_ni) begin
      dist_per_count = 24'd35701;
      min_gap_us = 20'd100;
      prev_count = '0;
      prev_stamp = '0;
      x_pos = 0;
      y_pos = 0;
      expected_pos_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == ehdr_pkg::RegDistPerCount) dist_per_count = cfg_data_i;
        else if (cfg_idx_i == ehdr_pkg::RegMinInterval) min_gap_us = cfg_data_i[19:0];
      end
      if (in_valid_i && !in_stall_i) begin
        elapsed = in_data_i.time_us - prev_stamp;
        res.accepted = elapsed >= {12'd0, min_gap_us};
        if (res.accepted) begin
          du = in_data_i.encoder_count - prev_count;
          travel = longint'($signed(du)) * longint'({40'd0, dist_per_count});
          heading_trig(in_data_i.heading_angle, c, s);
          x_pos = clamp_add(x_pos, scaled_step(travel, c));
          y_pos = clamp_add(y_pos, scaled_step(travel, s));
          prev_count = in_data_i.encoder_count;
          prev_stamp = in_data_i.time_us;
        end
        res.pos_x = x_pos[47:0];
        res.pos_y = y_pos[47:0];
        expected_pos_q.push_back(res);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_pos_q.size() == 0) begin
          report("unexpected result", out_data_i.pos_x, '0);
        end else begin
          want = expected_pos_q.pop_front();
          if (out_data_i.pos_x !== want.pos_x) report("pos_x", out_data_i.pos_x, want.pos_x);
          if (out_data_i.pos_y !== want.pos_y) report("pos_y", out_data_i.pos_y, want.pos_y);
          if (out_data_i.accepted !== want.accepted)
            report("accepted", 48'(out_data_i.accepted), 48'(want.accepted));
        end
      end
      pending_o = expected_pos_q.size();
    end
  end
endmodule
`default_nettype wire

>>> sim/encoder_heading_dead_reckoning_unit_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module encoder_heading_dead_reckoning_unit_tb;

  // An index past the register map; the block must ignore writes to it.
  localparam logic [ehdr_pkg::CfgIdxW-1:0] RegUnused = 2'd3;
  localparam int DrainCycles = 60;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  ehdr_pkg::in_item_t            in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  ehdr_pkg::out_item_t           out_data;
  logic                          cfg_we = 1'b0;
  logic [ehdr_pkg::CfgIdxW-1:0]  cfg_idx = '0;
  logic [ehdr_pkg::CfgDataW-1:0] cfg_data = '0;
  int                            fail_count;
  int                            pending;
  bit                            hold_off_req = 1'b0;

  // Sender-side copy of the settings and the last accepted tick, used to aim
  // timestamps near the acceptance boundary and to step counts from the last one.
  logic [31:0] track_stamp = '0;
  logic [31:0] cur_count = '0;
  logic [19:0] cur_gap = 20'd100;

  always #4 clk = ~clk;

  encoder_heading_dead_reckoning_unit dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  ehdr_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver: random stall bursts, mostly short, with quiet stretches and a
  // long hold-off on request.
  initial begin
    int left;
    int quiet;
    left = 0;
    quiet = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        hold_off_req = 1'b0;
        out_stall <= 1'b0;
      end else if (quiet > 0) begin
        quiet--;
        out_stall <= 1'b0;
      end else if (left > 0) begin
        left--;
        out_stall <= 1'b1;
      end else begin
        case ($urandom_range(0, 19))
          0: quiet = $urandom_range(50, 300);
          1: left = $urandom_range(20, 80);
          2, 3, 4, 5: left = $urandom_range(1, 4);
          default: ;
        endcase
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one transaction; called at a falling edge, returns at a falling
  // edge once the block has accepted it.
  task automatic send_tick(input logic [31:0] count, input logic [15:0] heading,
                           input logic [31:0] stamp);
    in_valid <= 1'b1;
    in_data <= '{encoder_count: count, heading_angle: heading, time_us: stamp};
    do @(posedge clk); while (in_stall);
    if (stamp - track_stamp >= {12'd0, cur_gap}) begin
      track_stamp = stamp;
      cur_count = count;
    end
    @(negedge clk);
  endtask

  // Drop valid for a random gap: usually none, sometimes short, rarely long.
  task automatic sender_gap();
    int gap;
    case ($urandom_range(0, 9))
      0, 1, 2: gap = $urandom_range(1, 3);
      3: gap = $urandom_range(20, 120);
      default: gap = 0;
    endcase
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Hold until every expected result is back, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [ehdr_pkg::CfgIdxW-1:0] idx,
                           input logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == ehdr_pkg::RegMinInterval) cur_gap = val[19:0];
    @(negedge clk);
  endtask

  // Random tick: mostly well spaced with small count steps, some near or below
  // the interval, some earlier than the last accepted stamp, some fully random.
  task automatic random_tick();
    logic [31:0] stamp, count;
    case ($urandom_range(0, 19))
      0, 1, 2: stamp = track_stamp + $urandom_range(0, cur_gap);
      3: stamp = $urandom();
      4: stamp = track_stamp - $urandom_range(1, 1000);
      default: stamp = track_stamp + cur_gap + $urandom_range(0, 400);
    endcase
    case ($urandom_range(0, 9))
      0: count = $urandom();
      1: count = cur_count + $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
      default: count = cur_count + $urandom_range(0, 8000) - 4000;
    endcase
    send_tick(count, 16'($urandom()), stamp);
    sender_gap();
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset settings, first tick, boundaries, heading extremes.
    send_tick(32'd5, 16'h0000, 32'd200);
    send_tick(32'd900, 16'h0000, 32'd299);           // too soon, rejected
    send_tick(32'd900, 16'h4000, 32'd300);           // exactly the interval
    send_tick(32'd2000, 16'h8000, 32'd500);          // most negative heading
    send_tick(32'd3000, 16'h7FFF, 32'd700);          // most positive heading
    send_tick(32'd4000, 16'hC000, 32'd900);
    send_tick(32'd5000, 16'h3FFF, 32'd1100);
    send_tick(32'd1000, 16'hBFFF, 32'd1300);         // negative step
    send_tick(32'h8000_03E8, 16'h2000, 32'd1500);    // most negative delta
    send_tick(32'h0000_03E8, 16'hE000, 32'd1700);    // most negative delta
    send_tick(32'hFFFF_FFFF, 16'h1234, 32'd1900);
    send_tick(32'h0000_0001, 16'h1234, 32'd2100);    // count wraps through zero
    send_tick(32'd10, 16'h0000, 32'd2050);           // time runs backwards
    send_tick(32'd20, 16'h0000, 32'hFFFF_FFFF);
    send_tick(32'd30, 16'h0000, 32'h0000_0063);      // wraps, 100 us elapsed
    drain();

    // Largest scale, no minimum: drive both axes into saturation and back.
    write_reg(ehdr_pkg::RegDistPerCount, 24'hFF_FFFF);
    write_reg(ehdr_pkg::RegMinInterval, 24'd0);
    write_reg(RegUnused, 24'h000_001);
    for (int i = 0; i < 6; i++)
      send_tick(cur_count + 32'h7FFF_FFFF, 16'h2000, track_stamp);
    for (int i = 0; i < 12; i++)
      send_tick(cur_count + 32'h8000_0000, 16'h2000, track_stamp);
    for (int i = 0; i < 6; i++)
      send_tick(cur_count + 32'h7FFF_FFFF, 16'hA000, track_stamp + 1);
    drain();

    // Long receiver hold-off while the sender keeps offering.
    hold_off_req = 1'b1;
    for (int i = 0; i < 8; i++)
      send_tick(cur_count + i, 16'($urandom()), track_stamp + 5);
    drain();

    write_reg(ehdr_pkg::RegDistPerCount, 24'd0);
    write_reg(ehdr_pkg::RegMinInterval, 24'd1000000);
    for (int i = 0; i < 40; i++) random_tick();
    drain();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          write_reg(ehdr_pkg::RegDistPerCount, 24'd35701);
          write_reg(ehdr_pkg::RegMinInterval, 24'd100);
        end
        1: begin
          write_reg(ehdr_pkg::RegDistPerCount, 24'hFF_FFFF);
          write_reg(ehdr_pkg::RegMinInterval, 24'd1);
        end
        default: begin
          write_reg(ehdr_pkg::RegDistPerCount, 24'($urandom()));
          write_reg(ehdr_pkg::RegMinInterval, 24'($urandom_range(0, 20'hF_FFFF)));
        end
      endcase
      for (int i = 0; i < 190; i++) random_tick();
      drain();
    end

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
rtl/ehdr_pkg.sv
rtl/ehdr_datapath.sv
rtl/ehdr_ctrl.sv
rtl/encoder_heading_dead_reckoning_unit.sv
sim/ehdr_checker.sv
sim/encoder_heading_dead_reckoning_unit_tb.sv
